>>> hw/rtl/rlew_word_run_decoder_top_assert.svh
// Assertion macros shared by the checker.
`ifndef RLEW_WORD_RUN_DECODER_TOP_ASSERT_SVH
`define RLEW_WORD_RUN_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define RLEW_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlew check failed");

// Next-cycle implication, off while in reset.
`define RLEW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlew check failed");

// Next-cycle implication that also holds across reset.
`define RLEW_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rlew check failed");

`endif

>>> hw/rtl/rlewd_pkg.sv
package rlewd_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LIT,
    PH_CNT,
    PH_VAL
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_HDR = 2'd1;
  localparam logic [1:0] ST_CLIP    = 2'd2;

  localparam logic CFG_ESCAPE_KEY   = 1'b0;
  localparam logic CFG_DROP_LEADING = 1'b1;

  localparam logic [15:0] ESCAPE_KEY_RESET   = 16'hFEFE;
  localparam logic        DROP_LEADING_RESET = 1'b1;

  typedef struct packed {
    logic [15:0] repeat_n;
    logic [14:0] offset;
    logic        last;
    logic [1:0]  status;
    logic [15:0] produced;
  } run_t;

endpackage

>>> hw/rtl/rlew_word_run_decoder_top.sv
// Channel  | Handshake            | Payload
// request  | req_valid, req_stall | word, start_req
// result   | res_valid, res_stall | value, repeat_res, offset, last, status
//
// One word per cycle while nothing stalls; a word that yields a descriptor goes
// through the input register, then is decoded into the result register.
// The phase machine and counters update in the decode stage.
// A word that yields a descriptor waits in the input register while the
// result register holds an untaken descriptor; words that yield none pass.
// rst clears phase, counters and both valids; escape_key resets to 0xFEFE,
// drop_leading to 1.
module rlew_word_run_decoder_top
  import rlewd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [15:0] word,
  input  logic        start_req,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] value,
  output logic [15:0] repeat_res,
  output logic [14:0] offset,
  output logic        last,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] escape_key;
  logic        drop_leading;

  logic        a_valid;
  logic [15:0] a_word;
  logic        a_start;

  phase_t      phase, phase_next;
  logic [14:0] total_elements, total_elements_next;
  logic [15:0] produced_elements, produced_elements_next;
  logic [15:0] pending_count, pending_count_next;

  logic        a_emit;
  logic        a_fire;
  logic        res_free;
  logic [15:0] emit_value;
  logic [15:0] emit_repeat;
  logic [14:0] emit_offset;
  logic        emit_last;
  logic [1:0]  emit_status;
  logic [15:0] run_count;
  run_t        run;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_key   <= ESCAPE_KEY_RESET;
      drop_leading <= DROP_LEADING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ESCAPE_KEY:   escape_key   <= cfg_data;
        CFG_DROP_LEADING: drop_leading <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign res_free  = !res_valid || !res_stall;
  assign a_fire    = a_valid && (!a_emit || res_free);
  assign req_stall = a_valid && !a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      a_word  <= word;
      a_start <= start_req;
    end
  end

  assign run_count = (phase == PH_VAL) ? pending_count : 16'd1;

  rlewd_run_calc u_calc (
    .count        (run_count),
    .total        (total_elements),
    .produced     (produced_elements),
    .drop_leading (drop_leading),
    .run          (run)
  );

  always_comb begin
    phase_next             = phase;
    total_elements_next    = total_elements;
    produced_elements_next = produced_elements;
    pending_count_next     = pending_count;
    a_emit                 = 1'b0;
    emit_value             = a_word;
    emit_repeat            = run.repeat_n;
    emit_offset            = run.offset;
    emit_last              = run.last;
    emit_status            = run.status;
    if (a_start) begin
      produced_elements_next = 16'd0;
      pending_count_next     = 16'd0;
      if (a_word < 16'd2 || a_word[0]) begin
        total_elements_next = 15'd0;
        phase_next          = PH_IDLE;
        a_emit              = 1'b1;
        emit_value          = 16'd0;
        emit_repeat         = 16'd0;
        emit_offset         = 15'd0;
        emit_last           = 1'b1;
        emit_status         = ST_BAD_HDR;
      end else begin
        total_elements_next = a_word[15:1];
        phase_next          = PH_LIT;
      end
    end else begin
      case (phase)
        PH_LIT: begin
          if (a_word == escape_key) begin
            phase_next = PH_CNT;
          end else begin
            a_emit                 = 1'b1;
            produced_elements_next = run.produced;
            if (run.last) phase_next = PH_IDLE;
          end
        end
        PH_CNT: begin
          pending_count_next = a_word;
          phase_next         = PH_VAL;
        end
        PH_VAL: begin
          a_emit                 = 1'b1;
          produced_elements_next = run.produced;
          phase_next             = run.last ? PH_IDLE : PH_LIT;
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      total_elements    <= 15'd0;
      produced_elements <= 16'd0;
      pending_count     <= 16'd0;
    end else if (a_fire) begin
      phase             <= phase_next;
      total_elements    <= total_elements_next;
      produced_elements <= produced_elements_next;
      pending_count     <= pending_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (a_fire && a_emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_emit) begin
      value      <= emit_value;
      repeat_res <= emit_repeat;
      offset     <= emit_offset;
      last       <= emit_last;
      status     <= emit_status;
    end
  end

endmodule

>>> hw/rtl/rlewd_run_calc.sv
module rlewd_run_calc
  import rlewd_pkg::*;
(
  input  logic [15:0] count,
  input  logic [14:0] total,
  input  logic [15:0] produced,
  input  logic        drop_leading,
  output run_t        run
);

  logic [14:0] remaining;
  logic        clip;
  logic [15:0] n;
  logic [15:0] sum;

  // produced never passes total, so its top bit is always clear
  assign remaining = total - produced[14:0];
  assign clip      = count > {1'b0, remaining};
  assign n         = clip ? {1'b0, remaining} : count;
  assign sum       = produced + n;

  always_comb begin
    run.produced = sum;
    run.last     = sum >= {1'b0, total};
    run.status   = clip ? ST_CLIP : ST_OK;
    if (drop_leading) begin
      if (produced == 16'd0) begin
        run.offset   = 15'd0;
        run.repeat_n = (n == 16'd0) ? 16'd0 : n - 16'd1;
      end else begin
        run.offset   = produced[14:0] - 15'd1;
        run.repeat_n = n;
      end
    end else begin
      run.offset   = produced[14:0];
      run.repeat_n = n;
    end
  end

endmodule

>>> hw/rtl/rlewd_checker.sv
`include "rlew_word_run_decoder_top_assert.svh"

module rlewd_checker
  import rlewd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic [15:0] value,
  input logic [15:0] repeat_res,
  input logic [14:0] offset,
  input logic        last,
  input logic [1:0]  status
);

  `RLEW_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(value) && $stable(repeat_res) && $stable(offset) && $stable(last) && $stable(status))

  `RLEW_ASSERT_IMPL(a_bad_hdr_form, res_valid && status == ST_BAD_HDR, last && value == 16'd0 && repeat_res == 16'd0 && offset == 15'd0)

  `RLEW_ASSERT_IMPL(a_clip_is_last, res_valid && status == ST_CLIP, last)

  `RLEW_ASSERT_NEXT_ALWAYS(a_reset_quiet, rst, !res_valid)

endmodule

bind rlew_word_run_decoder_top rlewd_checker u_rlewd_checker (.*);
